// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define AFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/afr_pkg.sv =====
package afr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam int AFR_QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] START_DELIM      = 8'h7E;
    localparam logic [BYTE_W-1:0] SUM_GOOD         = 8'hFF;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 16'd255;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic REG_IDX_MAX_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CSUM    = 3'd4
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  byte_index;
        logic              checksum_ok;
        logic [LEN_W-1:0]  frame_length;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/afr_in_if.sv =====
interface afr_in_if import afr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/afr_out_if.sv =====
interface afr_out_if import afr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  byte_index;
    logic              checksum_ok;
    logic [LEN_W-1:0]  frame_length;
    logic              last;

    modport source (
        output valid, output kind, output data_byte, output byte_index,
        output checksum_ok, output frame_length, output last, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input byte_index,
        input checksum_ok, input frame_length, input last, output ready
    );
endinterface

// ===== hdl/afr_front.sv =====
module afr_front import afr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    afr_in_if.sink           i_rx,
    input  logic [LEN_W-1:0] i_max_length,
    input  logic             i_full,
    output t_push            o_push
);

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_length, n_length;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]  r_sum, n_sum;
    logic               w_fire;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_count_inc;
    logic [BYTE_W-1:0]  w_sum_add;

    assign i_rx.ready  = !i_full;
    assign w_fire      = i_rx.valid && !i_full;
    assign w_len       = {r_length[LEN_W-1:BYTE_W], i_rx.rx_byte};
    assign w_count_inc = r_count + 1'b1;
    assign w_sum_add   = r_sum + i_rx.rx_byte;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (w_len > i_max_length) begin
                        n_phase = PH_HUNT;
                    end else if (w_len == '0) begin
                        n_phase = PH_CSUM;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (w_count_inc == r_length) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = (i_rx.rx_byte == START_DELIM) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
        end
    end

    // frame counters and queue writes
    always_comb begin
        n_length = r_length;
        n_count  = r_count;
        n_sum    = r_sum;
        o_push   = '0;
        if (w_fire) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_length = {i_rx.rx_byte, {BYTE_W{1'b0}}};
                end
                PH_LEN_LO: begin
                    n_length = w_len;
                    n_count  = '0;
                    n_sum    = '0;
                end
                PH_PAYLOAD: begin
                    n_count                   = w_count_inc;
                    n_sum                     = w_sum_add;
                    o_push.valid              = 1'b1;
                    o_push.entry.kind         = KIND_DATA;
                    o_push.entry.data_byte    = i_rx.rx_byte;
                    o_push.entry.byte_index   = r_count;
                    o_push.entry.frame_length = r_length;
                end
                PH_CSUM: begin
                    o_push.valid              = 1'b1;
                    o_push.entry.kind         = KIND_END;
                    o_push.entry.checksum_ok  = (w_sum_add == SUM_GOOD);
                    o_push.entry.frame_length = r_length;
                end
                default: begin
                    n_length = r_length;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_length <= '0;
            r_count  <= '0;
            r_sum    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
            r_sum    <= n_sum;
        end
    end

endmodule

// ===== hdl/afr_queue.sv =====
module afr_queue import afr_pkg::*; #(
    parameter int DEPTH = AFR_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_wr_en;
    logic               w_rd_en;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd];

    assign w_wr_en = i_push.valid && !o_status.full;
    assign w_rd_en = i_pop && !o_status.empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wr_en) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (w_rd_en && !w_wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/afr_back.sv =====
module afr_back import afr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_status i_status,
    output logic      o_pop,
    afr_out_if.source o_res
);

    logic   r_valid, n_valid;
    t_entry r_entry;

    assign o_pop   = !i_status.empty && (!r_valid || o_res.ready);
    assign n_valid = o_pop || (r_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_head;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_entry.kind;
    assign o_res.data_byte    = r_entry.data_byte;
    assign o_res.byte_index   = r_entry.byte_index;
    assign o_res.checksum_ok  = r_entry.checksum_ok;
    assign o_res.frame_length = r_entry.frame_length;
    assign o_res.last         = (r_entry.kind == KIND_END);

endmodule

// ===== hdl/api_frame_receiver_top.sv =====
// a result is written into the result queue at the edge that accepts its byte, then into the output register
// throughput: one byte per cycle, sustained while the output is taken
// the result queue (QUEUE_DEPTH entries) absorbs output stalls before input ready drops
// reset (synchronous, active low): parser hunts, queue and output empty, max_length 255
`include "assert_macros.svh"

module api_frame_receiver_top import afr_pkg::*; #(
    parameter int QUEUE_DEPTH = AFR_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    afr_in_if.sink                i_rx,
    afr_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LEN_W-1:0] r_max_length;
    logic             w_reg_idx;
    logic             w_cfg_wr;
    t_push            w_push;
    t_entry           w_head;
    t_q_status        w_qstat;
    logic             w_pop;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_ADDR_W-1];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = (w_reg_idx == REG_IDX_MAX_LENGTH)
                     ? {{(APB_DATA_W-LEN_W){1'b0}}, r_max_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (w_cfg_wr && (w_reg_idx == REG_IDX_MAX_LENGTH)) begin
            r_max_length <= pwdata[LEN_W-1:0];
        end
    end

    afr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_max_length (r_max_length),
        .i_full       (w_qstat.full),
        .o_push       (w_push)
    );

    afr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    afr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_qstat),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    `AFR_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, w_push.valid, !w_qstat.full, "result pushed into full queue")
    `AFR_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push.valid && !w_pop, !w_qstat.empty, "pushed result missing from queue")
    `AFR_ASSERT_IMPL(a_index_in_frame, i_clk, i_rst_n, o_res.valid && (o_res.kind == KIND_DATA), o_res.byte_index < o_res.frame_length, "payload index beyond frame length")

endmodule

// ===== bench/afr_frame_checker.sv =====
`timescale 1ns / 100ps

module afr_frame_checker import afr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    afr_in_if                     i_rx,
    afr_out_if                    i_res,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_good_frames,
    output int                    o_bad_frames,
    output int                    o_payload_bytes
);

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  byte_index;
        logic              checksum_ok;
        logic [LEN_W-1:0]  frame_length;
        logic              last;
    } t_frame_event;

    t_frame_event      frame_events_q[$];
    t_phase            parse_phase;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  byte_count;
    logic [LEN_W-1:0]  max_len;
    logic [BYTE_W-1:0] running_sum;
    int                fails;
    int                good_frames;
    int                bad_frames;
    int                payload_bytes;

    function automatic string describe(input t_frame_event e);
        return $sformatf("kind=%0d data=%02h index=%0d ok=%0d length=%0d last=%0d",
                         e.kind, e.data_byte, e.byte_index, e.checksum_ok,
                         e.frame_length, e.last);
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        t_frame_event      ev;
        logic [BYTE_W-1:0] total;
        case (parse_phase)
            PH_LEN_HI: begin
                frame_len   = {b, 8'h00};
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                frame_len = {frame_len[LEN_W-1:BYTE_W], b};
                if (frame_len > max_len) begin
                    parse_phase = PH_HUNT;
                end else begin
                    byte_count  = '0;
                    running_sum = '0;
                    parse_phase = (frame_len == '0) ? PH_CSUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                ev = '{kind: KIND_DATA, data_byte: b, byte_index: byte_count,
                       checksum_ok: 1'b0, frame_length: frame_len, last: 1'b0};
                frame_events_q.push_back(ev);
                payload_bytes++;
                running_sum = running_sum + b;
                byte_count  = byte_count + 1'b1;
                if (byte_count >= frame_len) begin
                    parse_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                total = running_sum + b;
                ev = '{kind: KIND_END, data_byte: '0, byte_index: '0,
                       checksum_ok: (total == SUM_GOOD), frame_length: frame_len,
                       last: 1'b1};
                frame_events_q.push_back(ev);
                if (total == SUM_GOOD) begin
                    good_frames++;
                end else begin
                    bad_frames++;
                end
                parse_phase = PH_HUNT;
            end
            default: begin
                parse_phase = (b == START_DELIM) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame_event seen;
        t_frame_event want;
        if (!i_rst_n) begin
            parse_phase = PH_HUNT;
            frame_len   = '0;
            byte_count  = '0;
            running_sum = '0;
            max_len     = MAX_LENGTH_RESET;
            frame_events_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_ADDR_W-1:2] == REG_IDX_MAX_LENGTH) begin
                max_len = i_pwdata[LEN_W-1:0];
            end
            if (i_res.valid && i_res.ready) begin
                seen = '{kind: i_res.kind, data_byte: i_res.data_byte,
                         byte_index: i_res.byte_index, checksum_ok: i_res.checksum_ok,
                         frame_length: i_res.frame_length, last: i_res.last};
                if (frame_events_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result %s", $time, describe(seen));
                end else begin
                    want = frame_events_q.pop_front();
                    if (seen !== want) begin
                        fails++;
                        $display("%0t: mismatch, expected %s", $time, describe(want));
                        $display("%0t:           actual   %s", $time, describe(seen));
                    end
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                parse_byte(i_rx.rx_byte);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= frame_events_q.size();
        o_good_frames   <= good_frames;
        o_bad_frames    <= bad_frames;
        o_payload_bytes <= payload_bytes;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import afr_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LENGTH = {REG_IDX_MAX_LENGTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_IDX_MAX_LENGTH, 2'b00};
    localparam int PHASE_BYTES   = 190;
    localparam int LATENCY_SLACK = 4;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  calm = 1'b0;
    logic [LEN_W-1:0]      cur_max = MAX_LENGTH_RESET;
    int                    sent = 0;
    int                    fail_count;
    int                    pending;
    int                    good_frames;
    int                    bad_frames;
    int                    payload_bytes;

    afr_in_if  rx_if ();
    afr_out_if res_if ();

    api_frame_receiver_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    afr_frame_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx            (rx_if),
        .i_res           (res_if),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_good_frames   (good_frames),
        .o_bad_frames    (bad_frames),
        .o_payload_bytes (payload_bytes)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver side: short random stalls and the odd long one
    initial begin
        int burst;
        burst = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (burst > 0) begin
                burst--;
                res_if.ready <= 1'b0;
            end else if (calm) begin
                res_if.ready <= 1'b1;
            end else if ($urandom_range(199) == 0) begin
                burst = $urandom_range(4, 12);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sent++;
        if (!calm && $urandom_range(99) < 10) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_LENGTH) begin
            cur_max = value[LEN_W-1:0];
        end
    endtask

    task automatic send_frame(input logic [LEN_W-1:0] len, input bit good_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        push_byte(START_DELIM);
        push_byte(len[LEN_W-1:BYTE_W]);
        push_byte(len[BYTE_W-1:0]);
        repeat (len) begin
            b = BYTE_W'($urandom);
            sum = sum + b;
            push_byte(b);
        end
        push_byte(good_sum ? SUM_GOOD - sum : BYTE_W'($urandom));
    endtask

    task automatic send_random_unit();
        int               r;
        int               cap;
        logic [LEN_W-1:0] len;
        r = $urandom_range(99);
        if (r < 8) begin
            push_byte(BYTE_W'($urandom));
        end else if (r < 14 && cur_max != 16'hFFFF) begin
            // header that is too long for the current limit
            len = (cur_max > 16'hFFD7) ? 16'hFFFF : cur_max + LEN_W'($urandom_range(1, 40));
            push_byte(START_DELIM);
            push_byte(len[LEN_W-1:BYTE_W]);
            push_byte(len[BYTE_W-1:0]);
        end else begin
            if (cur_max >= 256 && $urandom_range(39) == 0) begin
                cap = (cur_max < 300) ? cur_max : 300;
                len = LEN_W'($urandom_range(256, cap));
            end else begin
                cap = (cur_max < 24) ? cur_max : 24;
                len = LEN_W'($urandom_range(0, cap));
            end
            send_frame(len, $urandom_range(3) != 0);
        end
    endtask

    initial begin
        logic [LEN_W-1:0] phase_max [5];
        int               target;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while hunting, zero-length good and bad, delimiter as payload
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(16'd0, 1'b1);
        push_byte(START_DELIM);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(START_DELIM);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(START_DELIM);
        push_byte(8'h80);
        push_byte(8'h01);
        // oversized header is dropped
        push_byte(START_DELIM);
        push_byte(8'h01);
        push_byte(8'h00);

        // limit raised between the length bytes, unmapped write ignored
        wait_idle();
        write_reg(ADDR_MAX_LENGTH, 32'd3);
        push_byte(START_DELIM);
        push_byte(8'h00);
        wait_idle();
        write_reg(ADDR_MAX_LENGTH, 32'd10);
        write_reg(ADDR_UNMAPPED, 32'd0);
        push_byte(8'h04);
        repeat (5) push_byte(BYTE_W'($urandom));

        phase_max = '{16'd255, 16'd0, 16'hFFFF, LEN_W'($urandom_range(1, 65534)), 16'd7};
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_reg(ADDR_MAX_LENGTH, APB_DATA_W'(phase_max[p]));
            calm <= (p == 2);
            target = sent + PHASE_BYTES;
            while (sent < target) begin
                send_random_unit();
            end
        end
        calm <= 1'b0;
        wait_idle();

        $display("%0d bytes sent; %0d good and %0d bad frames, %0d payload bytes checked",
                 sent, good_frames, bad_frames, payload_bytes);
        $display("max_length settings went through 0, 7, 255, 65535 and a random value");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
